/* hdl/dsrt_pkg.sv */
// dsrt_pkg: field layouts, operation and status codes for the date sorted record table
// no dependencies; imported by date_sorted_record_table_top and tb_top
`default_nettype none

package dsrt_pkg;

  localparam int unsigned TDATA_W   = 96;
  localparam int unsigned TUSER_W   = 2;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned DATE_W    = YEAR_W + MONTH_W + DAY_W;
  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned COUNT_W   = 5;

  typedef enum logic [TUSER_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [TUSER_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // first member sits in the high bits, so day lands at bit 0
  typedef struct packed {
    logic [POS_W-1:0]     position;
    logic [PAYLOAD_W-1:0] payload;
    logic [YEAR_W-1:0]    year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
  } in_data_t;

  typedef struct packed {
    logic [PAYLOAD_W-1:0] entry_payload;
    logic [YEAR_W-1:0]    entry_year;
    logic [MONTH_W-1:0]   entry_month;
    logic [DAY_W-1:0]     entry_day;
    logic [COUNT_W-1:0]   count;
  } out_data_t;

  localparam int unsigned IN_DATA_W  = $bits(in_data_t);
  localparam int unsigned OUT_DATA_W = $bits(out_data_t);

endpackage

`default_nettype wire

/* hdl/date_sorted_record_table_top.sv */
// date_sorted_record_table_top: table of dated records kept in ascending date order
// depends on dsrt_pkg
`default_nettype none

// Holds up to DEPTH records (date plus payload) in one single-port-write, registered-read
// memory, ordered by date with equal dates kept in arrival order. Operation on
// s_axis_tuser: insert, remove at index, read at index; every transaction returns status on
// m_axis_tuser and the record count. One item is worked at a time by a small sequencer that
// moves records one at a time through the memory's read and write ports: an insert reads each
// record with a later date and writes it up one slot, then writes the new record into the gap;
// a remove reads each following record and writes it down one slot; a read reads the slot at
// the index. A rejected insert, an out-of-range index or an unused code goes straight to the
// result. The next transaction is taken once the result is loaded into the output register,
// even while that result still waits to be taken.
module date_sorted_record_table_top #(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // day[4:0], month[8:5], year[22:9], payload[86:23], position[90:87], zero fill
  input  logic [dsrt_pkg::TDATA_W-1:0]  s_axis_tdata,
  // operation[1:0]
  input  logic [dsrt_pkg::TUSER_W-1:0]  s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // count[4:0], entry_day[9:5], entry_month[13:10], entry_year[27:14],
  // entry_payload[91:28], zero fill
  output logic [dsrt_pkg::TDATA_W-1:0]  m_axis_tdata,
  // status[1:0]
  output logic [dsrt_pkg::TUSER_W-1:0]  m_axis_tuser
);

  import dsrt_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned EW = DATE_W + PAYLOAD_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_REM_RD,
    S_REM_WR,
    S_RD_DATA,
    S_FIN
  } state_e;

  state_e                  state_q;
  logic [CW-1:0]           fill_q;
  logic [CW-1:0]           idx_q;
  logic [DATE_W-1:0]       date_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  status_e                 status_q;
  logic [DATE_W-1:0]       ent_date_q;
  logic [PAYLOAD_BITS-1:0] ent_pay_q;
  logic                    out_valid_q;
  out_data_t               out_data_q;
  status_e                 out_status_q;

  logic [EW-1:0]           mem [DEPTH];
  logic [EW-1:0]           rdata_q;

  in_data_t                in_data;
  logic [XW-1:0]           pos_x;
  logic [XW-1:0]           fill_x;
  logic [CW-1:0]           idx_m1;
  logic [CW-1:0]           idx_p1;
  logic [DATE_W-1:0]       rd_date;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic                    rd_later;
  logic                    mem_we;
  logic [AW-1:0]           mem_wa;
  logic [AW-1:0]           mem_ra;
  logic [EW-1:0]           mem_wd;
  logic                    out_free;

  assign in_data  = in_data_t'(s_axis_tdata[IN_DATA_W-1:0]);
  assign pos_x    = XW'(in_data.position);
  assign fill_x   = XW'(fill_q);
  assign idx_m1   = idx_q - CW'(1);
  assign idx_p1   = idx_q + CW'(1);
  assign rd_date  = rdata_q[EW-1 -: DATE_W];
  assign rd_pay   = rdata_q[PAYLOAD_BITS-1:0];
  // the packed date {year, month, day} compares like year, then month, then day
  assign rd_later = rd_date > date_q;
  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'(out_data_q);
  assign m_axis_tuser  = out_status_q;

  // memory port control, one read and one write a cycle
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_q[AW-1:0];
    mem_wd = {date_q, pay_q};
    mem_ra = '0;
    unique case (state_q)
      S_IDLE: begin
        mem_ra = pos_x[AW-1:0];
      end
      S_INS_RD: begin
        mem_ra = idx_m1[AW-1:0];
        mem_we = (idx_q == '0);
      end
      S_INS_CMP: begin
        // either move the later record up or drop the new one into the gap
        mem_we = 1'b1;
        if (rd_later) begin
          mem_wd = rdata_q;
        end
      end
      S_REM_RD: begin
        mem_ra = idx_p1[AW-1:0];
      end
      S_REM_WR: begin
        mem_we = 1'b1;
        mem_wd = rdata_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_q       <= '0;
      idx_q        <= '0;
      date_q       <= '0;
      pay_q        <= '0;
      status_q     <= ST_OK;
      ent_date_q   <= '0;
      ent_pay_q    <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_status_q <= ST_OK;
    end else begin
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            date_q     <= {in_data.year, in_data.month, in_data.day};
            pay_q      <= in_data.payload[PAYLOAD_BITS-1:0];
            ent_date_q <= '0;
            ent_pay_q  <= '0;
            status_q   <= ST_OK;
            unique case (s_axis_tuser)
              OP_INSERT: begin
                if (fill_q == CW'(DEPTH)) begin
                  status_q <= ST_FULL;
                  state_q  <= S_FIN;
                end else begin
                  idx_q   <= fill_q;
                  state_q <= S_INS_RD;
                end
              end
              OP_REMOVE: begin
                if (pos_x >= fill_x) begin
                  status_q <= ST_RANGE;
                  state_q  <= S_FIN;
                end else begin
                  idx_q   <= CW'(pos_x);
                  state_q <= S_REM_RD;
                end
              end
              OP_READ: begin
                if (pos_x >= fill_x) begin
                  status_q <= ST_RANGE;
                  state_q  <= S_FIN;
                end else begin
                  state_q <= S_RD_DATA;
                end
              end
              default: begin
                state_q <= S_FIN;
              end
            endcase
          end
        end
        S_INS_RD: begin
          if (idx_q == '0) begin
            fill_q  <= fill_q + CW'(1);
            state_q <= S_FIN;
          end else begin
            state_q <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (rd_later) begin
            idx_q   <= idx_m1;
            state_q <= S_INS_RD;
          end else begin
            fill_q  <= fill_q + CW'(1);
            state_q <= S_FIN;
          end
        end
        S_REM_RD: begin
          if (idx_p1 >= fill_q) begin
            fill_q  <= fill_q - CW'(1);
            state_q <= S_FIN;
          end else begin
            state_q <= S_REM_WR;
          end
        end
        S_REM_WR: begin
          idx_q   <= idx_p1;
          state_q <= S_REM_RD;
        end
        S_RD_DATA: begin
          ent_date_q <= rd_date;
          ent_pay_q  <= rd_pay;
          state_q    <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_status_q             <= status_q;
            out_data_q.count         <= COUNT_W'(fill_q);
            out_data_q.entry_day     <= ent_date_q[DAY_W-1:0];
            out_data_q.entry_month   <= ent_date_q[DAY_W +: MONTH_W];
            out_data_q.entry_year    <= ent_date_q[DAY_W+MONTH_W +: YEAR_W];
            out_data_q.entry_payload <= PAYLOAD_W'(ent_pay_q);
            state_q                  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// tb_top: self-checking testbench for date_sorted_record_table_top, directed table then random
// depends on dsrt_pkg and date_sorted_record_table_top; keeps its own sorted table as predictor
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dsrt_pkg::*;

  localparam int unsigned DEPTH         = 16;
  localparam logic [TUSER_W-1:0] OP_NOP = 2'd3;
  localparam int unsigned RAND_ITEMS    = 850;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned DIR_ROWS      = 20;
  localparam int unsigned MAX_PRINTS    = 50;
  localparam int unsigned RX_FREE       = 0;
  localparam int unsigned RX_CHOPPY     = 1;
  localparam int unsigned RX_LIGHT      = 2;

  typedef struct packed {
    logic [YEAR_W-1:0]    year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
    logic [PAYLOAD_W-1:0] payload;
  } record_t;

  typedef struct packed {
    status_e   status;
    out_data_t data;
  } reply_t;

  // one directed row; typed rows carry their own expected reply
  typedef struct packed {
    logic [TUSER_W-1:0]   op;
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_W-1:0]    year;
    logic [PAYLOAD_W-1:0] payload;
    logic [POS_W-1:0]     position;
    logic [3:0]           reps;
    logic                 typed;
    status_e              st;
    logic [COUNT_W-1:0]   count;
    logic                 has_entry;
  } stim_row_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata  = '0;
  logic [TUSER_W-1:0]   s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic [TUSER_W-1:0]   m_axis_tuser;

  record_t      tbl_rec [DEPTH];
  int unsigned  tbl_count = 0;
  reply_t       pending_replies [$];
  int unsigned  mismatch_count = 0;
  int unsigned  burst_left = 1;
  bit           rx_hold_req = 1'b0;
  stim_row_t    dir_rows [DIR_ROWS];

  date_sorted_record_table_top #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned date_key(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                                           logic [DAY_W-1:0] d);
    return y * 10000 + m * 100 + d;
  endfunction

  // applies one operation to the shadow table and returns the reply it causes
  function automatic reply_t table_apply(logic [TUSER_W-1:0] op, in_data_t d);
    reply_t      r;
    int unsigned slot;
    int unsigned key;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (tbl_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          key  = date_key(d.year, d.month, d.day);
          slot = tbl_count;
          // equal keys stay ahead of the new record
          while (slot > 0 && date_key(tbl_rec[slot-1].year, tbl_rec[slot-1].month,
                                      tbl_rec[slot-1].day) > key) begin
            tbl_rec[slot] = tbl_rec[slot-1];
            slot--;
          end
          tbl_rec[slot] = '{d.year, d.month, d.day, d.payload};
          tbl_count++;
        end
      end
      OP_REMOVE: begin
        if (d.position >= tbl_count) begin
          r.status = ST_RANGE;
        end else begin
          for (int unsigned i = d.position; i + 1 < tbl_count; i++) tbl_rec[i] = tbl_rec[i+1];
          tbl_count--;
        end
      end
      OP_READ: begin
        if (d.position >= tbl_count) begin
          r.status = ST_RANGE;
        end else begin
          r.data.entry_day     = tbl_rec[d.position].day;
          r.data.entry_month   = tbl_rec[d.position].month;
          r.data.entry_year    = tbl_rec[d.position].year;
          r.data.entry_payload = tbl_rec[d.position].payload;
        end
      end
      default: ;
    endcase
    r.data.count = COUNT_W'(tbl_count);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // offers one transaction, then maybe drops valid for a gap between bursts
  task automatic send_item(logic [TUSER_W-1:0] op, in_data_t d, bit typed, reply_t typed_r);
    reply_t pred;
    int unsigned gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= TDATA_W'(d);
    do @(posedge clk_i); while (!s_axis_tready);
    pred = table_apply(op, d);
    pending_replies = {pending_replies, (typed ? typed_r : pred)};
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = $urandom_range(1, 8);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom, $urandom};
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // stop offering so the last transaction is not taken twice, then wait for every result
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // receiver: stall pattern changes per stretch; a hold request stalls for a long run
  initial begin
    int unsigned stretch;
    int unsigned mode;
    forever begin
      stretch = $urandom_range(10, 60);
      mode    = $urandom_range(RX_FREE, RX_LIGHT);
      repeat (stretch) begin
        @(negedge clk_i);
        if (rx_hold_req) begin
          m_axis_tready <= 1'b0;
          repeat (HOLD_CYCLES - 1) @(negedge clk_i);
          rx_hold_req = 1'b0;
        end else begin
          case (mode)
            RX_FREE:   m_axis_tready <= 1'b1;
            RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
            default:   m_axis_tready <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_data_t got;
    reply_t    want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[OUT_DATA_W-1:0];
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("result with none pending: status %0d count %0d",
                                  m_axis_tuser, got.count));
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", m_axis_tuser, want.status));
        if (got.count !== want.data.count)
          report_mismatch($sformatf("count %0d, want %0d", got.count, want.data.count));
        if (got.entry_day !== want.data.entry_day)
          report_mismatch($sformatf("entry_day %0d, want %0d", got.entry_day,
                                    want.data.entry_day));
        if (got.entry_month !== want.data.entry_month)
          report_mismatch($sformatf("entry_month %0d, want %0d", got.entry_month,
                                    want.data.entry_month));
        if (got.entry_year !== want.data.entry_year)
          report_mismatch($sformatf("entry_year %0d, want %0d", got.entry_year,
                                    want.data.entry_year));
        if (got.entry_payload !== want.data.entry_payload)
          report_mismatch($sformatf("entry_payload %h, want %h", got.entry_payload,
                                    want.data.entry_payload));
      end
    end
  end

  initial begin
    logic [TUSER_W-1:0]   op;
    in_data_t             d;
    reply_t               typed_r;
    stim_row_t            row;
    logic [DATE_W-1:0]    date_pool [6];
    bit                   draining;
    int unsigned          sel;

    // op, day, month, year, payload, position, reps, typed, status, count, has_entry
    dir_rows[0]  = '{OP_READ,   5'd0,  4'd0,  14'd0,     64'h0, 4'd0,  4'd1, 1'b1,
                     ST_RANGE, 5'd0, 1'b0};
    dir_rows[1]  = '{OP_REMOVE, 5'd0,  4'd0,  14'd0,     64'h0, 4'd15, 4'd1, 1'b1,
                     ST_RANGE, 5'd0, 1'b0};
    // unused code with every input bit set leaves the table alone
    dir_rows[2]  = '{OP_NOP,    5'd31, 4'd15, 14'd16383, '1,    4'd15, 4'd1, 1'b1,
                     ST_OK, 5'd0, 1'b0};
    dir_rows[3]  = '{OP_INSERT, 5'd31, 4'd12, 14'd9999,  '1,    4'd0,  4'd1, 1'b1,
                     ST_OK, 5'd1, 1'b0};
    dir_rows[4]  = '{OP_INSERT, 5'd0,  4'd0,  14'd0,     64'h0, 4'd0,  4'd1, 1'b1,
                     ST_OK, 5'd2, 1'b0};
    dir_rows[5]  = '{OP_READ,   5'd0,  4'd0,  14'd0,     64'h0, 4'd0,  4'd1, 1'b1,
                     ST_OK, 5'd2, 1'b1};
    dir_rows[6]  = '{OP_READ,   5'd31, 4'd12, 14'd9999,  '1,    4'd1,  4'd1, 1'b1,
                     ST_OK, 5'd2, 1'b1};
    dir_rows[7]  = '{OP_INSERT, 5'd31, 4'd15, 14'd16383, 64'ha5a5_a5a5_a5a5_a5a5, 4'd3,
                     4'd1, 1'b0, ST_OK, 5'd0, 1'b0};
    // same key as an earlier record, must land behind it
    dir_rows[8]  = '{OP_INSERT, 5'd31, 4'd12, 14'd9999,  64'h5555_5555_5555_5555, 4'd0,
                     4'd1, 1'b0, ST_OK, 5'd0, 1'b0};
    dir_rows[9]  = '{OP_READ,   5'd0,  4'd0,  14'd0,     64'h0, 4'd2,  4'd1, 1'b0,
                     ST_OK, 5'd0, 1'b0};
    dir_rows[10] = '{OP_READ,   5'd0,  4'd0,  14'd0,     64'h0, 4'd3,  4'd1, 1'b0,
                     ST_OK, 5'd0, 1'b0};
    dir_rows[11] = '{OP_INSERT, 5'd7,  4'd3,  14'd2000,  64'h1234_5678_9abc_0000, 4'd0,
                     4'd6, 1'b0, ST_OK, 5'd0, 1'b0};
    // early date, so every held record but the all-zero date and earlier copies of this one shifts up
    dir_rows[12] = '{OP_INSERT, 5'd1,  4'd1,  14'd1,     64'hfedc_ba98_7654_3200, 4'd0,
                     4'd6, 1'b0, ST_OK, 5'd0, 1'b0};
    dir_rows[13] = '{OP_INSERT, 5'd9,  4'd9,  14'd1999,  64'h0f0f_0f0f_0f0f_0f0f, 4'd0,
                     4'd1, 1'b1, ST_FULL, 5'd16, 1'b0};
    dir_rows[14] = '{OP_READ,   5'd0,  4'd0,  14'd0,     64'h0, 4'd15, 4'd1, 1'b0,
                     ST_OK, 5'd0, 1'b0};
    dir_rows[15] = '{OP_REMOVE, 5'd0,  4'd0,  14'd0,     64'h0, 4'd0,  4'd1, 1'b0,
                     ST_OK, 5'd0, 1'b0};
    dir_rows[16] = '{OP_REMOVE, 5'd0,  4'd0,  14'd0,     64'h0, 4'd14, 4'd1, 1'b0,
                     ST_OK, 5'd0, 1'b0};
    dir_rows[17] = '{OP_READ,   5'd0,  4'd0,  14'd0,     64'h0, 4'd14, 4'd1, 1'b1,
                     ST_RANGE, 5'd14, 1'b0};
    dir_rows[18] = '{OP_REMOVE, 5'd0,  4'd0,  14'd0,     64'h0, 4'd15, 4'd1, 1'b1,
                     ST_RANGE, 5'd14, 1'b0};
    dir_rows[19] = '{OP_READ,   5'd0,  4'd0,  14'd0,     64'h0, 4'd7,  4'd1, 1'b0,
                     ST_OK, 5'd0, 1'b0};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      for (int unsigned k = 0; k < row.reps; k++) begin
        d = '{row.position, row.payload + k, row.year, row.month, row.day};
        typed_r = '0;
        typed_r.status = row.st;
        typed_r.data.count = row.count;
        if (row.has_entry) begin
          typed_r.data.entry_day     = row.day;
          typed_r.data.entry_month   = row.month;
          typed_r.data.entry_year    = row.year;
          typed_r.data.entry_payload = row.payload;
        end
        send_item(row.op, d, row.typed, typed_r);
      end
    end

    // a few shared dates so equal keys keep showing up
    foreach (date_pool[p]) date_pool[p] = {14'($urandom_range(0, 9999)),
                                           4'($urandom_range(0, 12)),
                                           5'($urandom_range(0, 31))};
    draining = 1'b0;
    typed_r  = '0;
    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      if (n == 200) rx_hold_req = 1'b1;
      if (n == 500) wait_drained();

      if (tbl_count == 0) draining = 1'b0;
      else if (tbl_count == DEPTH && $urandom_range(0, 3) == 0) draining = 1'b1;

      sel = $urandom_range(0, 99);
      if (sel < 4)                       op = OP_NOP;
      else if (sel < 24)                 op = OP_READ;
      else if (sel < (draining ? 84 : 38)) op = OP_REMOVE;
      else                               op = OP_INSERT;

      sel = $urandom_range(0, 2);
      if (sel == 0) begin
        {d.year, d.month, d.day} = date_pool[$urandom_range(0, 5)];
      end else if (sel == 1) begin
        d.year  = 14'($urandom_range(0, 9999));
        d.month = 4'($urandom_range(0, 12));
        d.day   = 5'($urandom_range(0, 31));
      end else begin
        {d.year, d.month, d.day} = DATE_W'($urandom);
      end
      d.payload = {$urandom, $urandom};
      if (tbl_count > 0 && $urandom_range(0, 4) != 0)
        d.position = POS_W'($urandom_range(0, tbl_count - 1));
      else
        d.position = POS_W'($urandom_range(0, 15));

      send_item(op, d, 1'b0, typed_r);
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
